>>> rtl/socc_pkg.sv
// Shared constants, configuration type and fold function for the sampled checksum.
package socc_pkg;

    // Buffers of 2**SAMPLE_LIMIT_LOG2 bytes and more are sampled with a stride.
    localparam int SAMPLE_LIMIT_LOG2 = 21;
    localparam int LEN_W             = 32;
    localparam int STRIDE_W          = LEN_W - SAMPLE_LIMIT_LOG2;
    localparam int STRIDE2_W         = STRIDE_W + 1;
    localparam int SUM_W             = 32;
    localparam int CSUM_W            = 16;
    localparam int BYTE_W            = 8;

    // Values derived from the buffer length when it is written.
    typedef struct packed {
        logic [LEN_W-1:0]     last_pos;     // offset of the final byte
        logic [LEN_W-1:0]     sample_limit; // a word at offset o is summed when o < this
        logic [STRIDE2_W-1:0] stride2;      // distance between sampled words
        logic                 tail_add;     // add the final byte on its own
    } socc_cfg_t;

    // Fold a 32-bit sum to 16 bits with end-around carry and invert it.
    function automatic logic [CSUM_W-1:0] fold_invert(input logic [SUM_W-1:0] s);
        logic [CSUM_W:0] first;
        logic [CSUM_W:0] second;
        first  = {1'b0, s[SUM_W-1:CSUM_W]} + {1'b0, s[CSUM_W-1:0]};
        second = {{CSUM_W{1'b0}}, first[CSUM_W]} + {1'b0, first[CSUM_W-1:0]};
        return ~second[CSUM_W-1:0];
    endfunction

endpackage

>>> rtl/socc_cfg.sv
// Length register with the sampling values derived from it.
module socc_cfg
    import socc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic [LEN_W-1:0] cfg_byte_count,
    output logic             cfg_write,
    output socc_cfg_t        cfg
);

    socc_cfg_t            cfg_reg;
    socc_cfg_t            cfg_next;
    logic [LEN_W-1:0]     len_eff;
    logic                 sampled;
    logic [STRIDE2_W-1:0] stride2;

    assign cfg_write = cfg_valid;

    // A zero length acts as one; long buffers sample at every 2*stride bytes.
    always_comb begin
        len_eff = (cfg_byte_count == '0) ? LEN_W'(1) : cfg_byte_count;
        sampled = (len_eff[LEN_W-1:SAMPLE_LIMIT_LOG2] != '0);
        stride2 = sampled ? {len_eff[LEN_W-1:SAMPLE_LIMIT_LOG2], 1'b0} : STRIDE2_W'(2);
        cfg_next.last_pos     = len_eff - LEN_W'(1);
        cfg_next.sample_limit = sampled ? (len_eff - LEN_W'(stride2) - LEN_W'(1))
                                        : (len_eff - LEN_W'(1));
        cfg_next.stride2      = stride2;
        cfg_next.tail_add     = sampled | len_eff[0];
    end

    // Reset gives a one-byte buffer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.last_pos     <= '0;
            cfg_reg.sample_limit <= '0;
            cfg_reg.stride2      <= STRIDE2_W'(2);
            cfg_reg.tail_add     <= 1'b1;
        end else if (cfg_valid) begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/socc_core.sv
// Input register, running sum and result register of the checksum.
module socc_core
    import socc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_write,
    input  socc_cfg_t         cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CSUM_W-1:0] m_checksum
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [LEN_W-1:0]  pos_reg;
    logic [LEN_W-1:0]  sample_reg;
    logic [BYTE_W-1:0] held_reg;
    logic              out_valid_reg;
    logic [CSUM_W-1:0] out_csum_reg;
    logic              proc_fire;
    logic              word_add;
    logic              is_last;
    logic [SUM_W-1:0]  word_val;
    logic [SUM_W-1:0]  tail_val;

    // The held item moves on when the result slot is free or being emptied.
    assign proc_fire = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready   = ~in_valid_reg | proc_fire;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
        end
    end

    // Word completion, end of buffer and the new sum.
    always_comb begin
        word_add = ({1'b0, pos_reg} == ({1'b0, sample_reg} + (LEN_W+1)'(1)))
                   && (sample_reg < cfg.sample_limit);
        is_last  = (pos_reg >= cfg.last_pos);
        word_val = word_add ? {{(SUM_W-2*BYTE_W){1'b0}}, in_byte_reg, held_reg} : '0;
        tail_val = (is_last && cfg.tail_add) ? SUM_W'(in_byte_reg) : '0;
        sum_next = sum_reg + word_val + tail_val;
    end

    // Buffer state; a length write or the final byte starts a new buffer.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_write) begin
            sum_reg    <= '0;
            pos_reg    <= '0;
            sample_reg <= '0;
            held_reg   <= '0;
        end else if (proc_fire) begin
            if (pos_reg == sample_reg) begin
                held_reg <= in_byte_reg;
            end
            if (is_last) begin
                sum_reg    <= '0;
                pos_reg    <= '0;
                sample_reg <= '0;
            end else begin
                sum_reg <= sum_next;
                pos_reg <= pos_reg + LEN_W'(1);
                if (word_add) begin
                    sample_reg <= sample_reg + LEN_W'(cfg.stride2);
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && is_last) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && is_last) begin
            out_csum_reg <= fold_invert(sum_next);
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_checksum = out_csum_reg;

endmodule

>>> rtl/sampled_ones_complement_checksum.sv
// Top level of the sampled ones'-complement checksum.
//
// A buffer enters on the s_ channel, one byte per item, first byte first.
// Its length is written on the cfg channel; a write also starts a new buffer.
// The user must write only while no item is in flight; the block does not
// enforce this. cfg_ready is always high. Buffers under 2 MiB sum every
// little-endian 16-bit word plus an odd final byte; longer ones sum words at
// a stride of 2*(length >> 21) bytes and then add the final byte. With the
// final byte the m_ channel carries one item: the folded, inverted 16-bit
// sum. The next byte then opens a new buffer of the same length. Each item
// passes an input register and, for the final byte, a result register, which
// takes the checksum when the final byte leaves the input register. One byte
// is accepted every cycle while the result register is free or being emptied.
// When the receiver stalls, the result holds, one more byte waits in the input
// register and s_ready then drops. Reset (aresetn low, synchronous) sets a
// length of one byte and clears the sum and both registers.
module sampled_ones_complement_checksum
    import socc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LEN_W-1:0]  cfg_byte_count,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_data_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CSUM_W-1:0] m_checksum
);

    socc_cfg_t cfg;
    logic      cfg_write;

    assign cfg_ready = 1'b1;

    // Length register.
    socc_cfg u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_byte_count (cfg_byte_count),
        .cfg_write      (cfg_write),
        .cfg            (cfg)
    );

    // Checksum datapath.
    socc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_write   (cfg_write),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_checksum  (m_checksum)
    );

endmodule

>>> test/sampled_ones_complement_checksum_test.sv
// Testbench of the sampled ones'-complement checksum, with its own prediction of each result.
`timescale 1ns / 1ps

module sampled_ones_complement_checksum_test;
    import socc_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_byte_count;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_data_byte;
    logic              m_valid;
    logic              m_ready;
    logic [CSUM_W-1:0] m_checksum;

    // Predicted state of the block: buffer length and the sum in progress.
    logic [LEN_W-1:0]  length_reg   = 1;
    logic [SUM_W-1:0]  partial_sum  = '0;
    logic [LEN_W-1:0]  byte_offset  = '0;
    logic [LEN_W-1:0]  word_offset  = '0;
    logic [BYTE_W-1:0] pending_low  = '0;

    logic [CSUM_W-1:0] owed_checksums[$];
    int                mismatches   = 0;
    int                sent_total   = 0;
    int                gap_pct      = 0;
    bit                idle_allowed = 1'b1;

    sampled_ones_complement_checksum dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_byte_count (cfg_byte_count),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_checksum     (m_checksum)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Run limit, far above the slowest correct run.
    initial begin
        #150_000_000;
        $display("sampled_ones_complement_checksum_test NOT OK");
        $finish;
    end

    function automatic void clear_buffer_sums();
        partial_sum = '0;
        byte_offset = '0;
        word_offset = '0;
        pending_low = '0;
    endfunction

    // Take one byte into the predicted sum; returns 1 with the checksum when it ends a buffer.
    function automatic bit absorb_byte(input logic [BYTE_W-1:0] value,
                                       output logic [CSUM_W-1:0] csum);
        logic [63:0]      len;
        logic [63:0]      stride;
        logic [63:0]      pos;
        logic [63:0]      word_at;
        logic [SUM_W-1:0] folded;
        bit               sampled_mode;
        bit               word_counts;
        len          = (length_reg == 0) ? 64'd1 : {32'd0, length_reg};
        sampled_mode = len >= (64'd1 << SAMPLE_LIMIT_LOG2);
        stride       = sampled_mode ? (len >> SAMPLE_LIMIT_LOG2) : 64'd1;
        pos          = {32'd0, byte_offset};
        word_at      = {32'd0, word_offset};
        word_counts  = sampled_mode ? (word_at + 2 * stride + 1 < len) : (word_at + 1 < len);
        csum         = '0;

        // The high byte of a counted word completes it; the byte at a word's start is held.
        if (pos == word_at + 1 && word_counts) begin
            partial_sum = partial_sum + {16'd0, value, pending_low};
            word_offset = LEN_W'(word_at + 2 * stride);
        end else if (pos == word_at) begin
            pending_low = value;
        end

        if (pos + 1 >= len) begin
            if (sampled_mode || len[0])
                partial_sum = partial_sum + {24'd0, value};
            folded = partial_sum;
            while (folded[31:16] != 0)
                folded = {16'd0, folded[31:16]} + {16'd0, folded[15:0]};
            csum = ~folded[15:0];
            clear_buffer_sums();
            return 1'b1;
        end
        byte_offset = byte_offset + 1;
        return 1'b0;
    endfunction

    // Random byte with the two extremes favored.
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // Send one byte, after an occasional random idle burst, and record its result if it ends a buffer.
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        logic [CSUM_W-1:0] csum;
        if (sent_total % 40 == 0)
            gap_pct = 10 * $urandom_range(0, 3);
        sent_total++;
        if (idle_allowed && $urandom_range(0, 99) < gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (absorb_byte(value, csum))
            owed_checksums.push_back(csum);
    endtask

    // Write the buffer length once the block has gone quiet.
    task automatic set_length(input logic [LEN_W-1:0] len);
        s_valid <= 1'b0;
        while (owed_checksums.size() != 0) @(posedge aclk);
        // A byte that ends no buffer may still sit in the input register.
        repeat (6) @(posedge aclk);
        cfg_valid      <= 1'b1;
        cfg_byte_count <= len;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        length_reg = len;
        clear_buffer_sums();
    endtask

    // The length after reset is one byte, so each byte is a buffer of its own.
    task automatic test_reset_length();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_byte(8'h80);
    endtask

    // A length of zero behaves as a length of one.
    task automatic test_zero_length();
        set_length(0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h5A);
    endtask

    // Even and odd short buffers, with sums that need the end-around carry.
    task automatic test_short_buffers();
        set_length(2);
        repeat (2) send_byte(8'hFF);
        set_length(3);
        repeat (3) send_byte(8'hFF);
        set_length(4);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
    endtask

    // A length write in the middle of a buffer drops it and starts a new one.
    task automatic test_restart_mid_buffer();
        set_length(6);
        repeat (3) send_byte(pick_byte());
        set_length(32'hFFFF_FFFF);
        repeat (3) send_byte(pick_byte());
        set_length(4);
        repeat (4) send_byte(pick_byte());
    endtask

    // Mostly whole buffers of small random lengths, some cut short, a few huge lengths.
    task automatic test_random_buffers();
        int sent;
        int roll;
        int len;
        int count;
        sent = 0;
        while (sent < 1000) begin
            if (sent > 850)
                idle_allowed = 1'b0;
            roll = $urandom_range(0, 15);
            if (roll == 0)
                len = $urandom;
            else if (roll == 1)
                len = $urandom_range(0, 3);
            else
                len = $urandom_range(1, 24);
            set_length(len);
            if (roll == 0 || $urandom_range(0, 7) == 0)
                count = $urandom_range(1, 20);
            else
                count = $urandom_range(1, 4) * ((len == 0) ? 1 : len);
            repeat (count) send_byte(pick_byte());
            sent += count;
        end
    endtask

    // Receiver stalls in bursts, with the stall rate redrawn now and then.
    initial begin : drive_ready
        int cycle;
        int stall_pct;
        cycle     = 0;
        stall_pct = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            cycle++;
            if (cycle % 64 == 0)
                stall_pct = 10 * $urandom_range(0, 3);
            if (idle_allowed && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Compare each checksum taken from the block with the oldest one owed.
    initial begin : check_results
        logic [CSUM_W-1:0] want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (owed_checksums.size() == 0) begin
                    $display("%0t: checksum expected none, actual %h", $time, m_checksum);
                    mismatches++;
                end else begin
                    want = owed_checksums.pop_front();
                    if (m_checksum !== want) begin
                        $display("%0t: checksum expected %h, actual %h",
                                 $time, want, m_checksum);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Reset, then the tests in turn, then drain and report.
    initial begin
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_byte_count <= '0;
        s_valid        <= 1'b0;
        s_data_byte    <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_length();
        test_zero_length();
        test_short_buffers();
        test_restart_mid_buffer();
        test_random_buffers();

        s_valid <= 1'b0;
        while (owed_checksums.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("sampled_ones_complement_checksum_test OK");
        else
            $display("sampled_ones_complement_checksum_test NOT OK");
        $finish;
    end

endmodule
